// ===== src/lrupfr_pkg.sv =====
// ============================================================================
// lrupfr_pkg
// Shared types and constants for the LRU page frame replacer.
// ============================================================================
`default_nettype none

package lrupfr_pkg;

    // Sizing
    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;
    localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W    = SLOT_W;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int CFG_W     = 4;
    localparam int FAULT_W   = 32;
    localparam int OSLOT_W   = 3;

    localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = CFG_W'(3);
    localparam logic [FAULT_W-1:0] FAULT_MAX         = {FAULT_W{1'b1}};

    typedef logic [FRAMES-1:0][PAGE_BITS-1:0] page_array_t;
    typedef logic [FRAMES-1:0][RANK_W-1:0]    rank_array_t;
    typedef logic [FRAMES-1:0]                valid_vec_t;

    // Per-frame state of the replacer, plus the shared fault count
    typedef struct packed {
        page_array_t          page;
        valid_vec_t           valid;
        rank_array_t          rank;
        logic [FAULT_W-1:0]   faults;
    } lrupfr_state_t;

    // One result item
    typedef struct packed {
        logic                 hit;
        logic [OSLOT_W-1:0]   frame_slot;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [FAULT_W-1:0]   fault_count;
    } lrupfr_result_t;

endpackage

`default_nettype wire

// ===== src/lrupfr_update.sv =====
// ============================================================================
// lrupfr_update
// Single-pass lookup, victim choice and state update for one page reference.
// ============================================================================
`default_nettype none

module lrupfr_update (
    input  lrupfr_pkg::lrupfr_state_t             cur_state,
    input  logic [lrupfr_pkg::CFG_W-1:0]           frames_in_use,
    input  logic [lrupfr_pkg::PAGE_BITS-1:0]       page_number,
    input  logic                                   end_of_sequence,
    output lrupfr_pkg::lrupfr_state_t             nxt_state,
    output lrupfr_pkg::lrupfr_result_t            result
);
    import lrupfr_pkg::*;

    valid_vec_t          in_use;
    valid_vec_t          hit_vec;
    valid_vec_t          empty_vec;
    logic                hit;
    logic                found;
    logic [SLOT_W-1:0]   hit_idx;
    logic [SLOT_W-1:0]   empty_idx;
    logic [SLOT_W-1:0]   lru_idx;
    logic [SLOT_W-1:0]   slot;
    logic [RANK_W-1:0]   old_rank;
    logic [CNT_W-1:0]    nv;
    logic                touch;
    logic [FAULT_W-1:0]  faults_upd;
    lrupfr_state_t       upd;

    // In-use mask: a zero register acts as one frame
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            in_use[i]    = (32'(frames_in_use) > 32'(i)) || (i == 0);
            hit_vec[i]   = in_use[i] && cur_state.valid[i] &&
                           (cur_state.page[i] == page_number);
            empty_vec[i] = in_use[i] && !cur_state.valid[i];
        end
    end

    // Lowest-index hit and lowest-index empty frame
    always_comb begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (empty_vec[i]) begin
                empty_idx = SLOT_W'(i);
            end
        end
        hit   = |hit_vec;
        found = |empty_vec;
    end

    // Least recently used in-use frame, first lowest rank wins
    always_comb begin
        lru_idx = '0;
        for (int i = 1; i < FRAMES; i++) begin
            if (in_use[i] && (cur_state.rank[i] < cur_state.rank[lru_idx])) begin
                lru_idx = SLOT_W'(i);
            end
        end
    end

    assign nv       = CNT_W'($countones(cur_state.valid));
    assign slot     = hit ? hit_idx : (found ? empty_idx : lru_idx);
    assign old_rank = cur_state.rank[slot];
    assign touch    = hit || !found;

    // Saturating fault count, counted on every miss
    assign faults_upd = (hit || (cur_state.faults == FAULT_MAX)) ?
                        cur_state.faults : cur_state.faults + FAULT_W'(1);

    // Next frame contents and recency order
    always_comb begin
        upd        = cur_state;
        upd.faults = faults_upd;
        if (touch) begin
            for (int j = 0; j < FRAMES; j++) begin
                if (cur_state.valid[j] && (cur_state.rank[j] > old_rank)) begin
                    upd.rank[j] = cur_state.rank[j] - RANK_W'(1);
                end
            end
            upd.rank[slot] = RANK_W'(nv - CNT_W'(1));
        end else begin
            upd.rank[slot]  = RANK_W'(nv);
            upd.valid[slot] = 1'b1;
        end
        if (!hit) begin
            upd.page[slot] = page_number;
        end
    end

    // Sequence end clears the order, valid bits and count
    always_comb begin
        nxt_state = upd;
        if (end_of_sequence) begin
            nxt_state.valid  = '0;
            nxt_state.rank   = '0;
            nxt_state.faults = '0;
        end
    end

    // Result item
    always_comb begin
        result.hit           = hit;
        result.frame_slot    = OSLOT_W'(slot);
        result.evicted_valid = !hit && !found;
        result.evicted_page  = (!hit && !found) ? cur_state.page[slot] : '0;
        result.fault_count   = faults_upd;
    end

endmodule

`default_nettype wire

// ===== src/lru_page_frame_replacer_core.sv =====
// ============================================================================
// lru_page_frame_replacer_core
// Fully associative LRU page frame replacer with fault counting.
// ============================================================================
// Usage:
//   s_ channel carries one page reference per item (page number and an
//   end-of-sequence flag). m_ channel returns one result per item: hit flag,
//   frame slot now holding the page, evicted page (if any) and the running
//   fault count. Both channels use valid/ready.
//   cfg_wr_en/cfg_wr_data write frames_in_use (reset value 3); write it only
//   while no item is in flight.
//   An accepted item is registered in the input register; its result is then
//   registered in the result register once that has room, and shown on m_valid from then on.
//   Throughput: one item per cycle while the receiver keeps m_ready high; the
//   lookup compares all frames in parallel between the input and result registers.
//   Reset: all frames invalid, recency order and fault count cleared.
//   Receiver stall: the result register holds; the input register still takes
//   one more item, then s_ready drops until the result is taken.
//   An item with end_of_sequence set clears frames, order and count after
//   its own result is formed.
// ============================================================================
`default_nettype none

module lru_page_frame_replacer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [lrupfr_pkg::CFG_W-1:0]        cfg_wr_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lrupfr_pkg::PAGE_BITS-1:0]    s_page_number,
    input  logic                                s_end_of_sequence,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [lrupfr_pkg::OSLOT_W-1:0]      m_frame_slot,
    output logic                                m_evicted_valid,
    output logic [lrupfr_pkg::PAGE_BITS-1:0]    m_evicted_page,
    output logic [lrupfr_pkg::FAULT_W-1:0]      m_fault_count
);
    import lrupfr_pkg::*;

    logic [CFG_W-1:0]      frames_in_use_reg;
    logic                  in_valid_reg;
    logic [PAGE_BITS-1:0]  in_page_reg;
    logic                  in_eos_reg;
    logic                  out_valid_reg;
    lrupfr_result_t        out_reg;
    lrupfr_state_t         state_reg;
    lrupfr_state_t         state_next;
    lrupfr_result_t        out_next;
    logic                  advance;

    // Move the input item into the result register when there is room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    lrupfr_update u_update (
        .cur_state       (state_reg),
        .frames_in_use   (frames_in_use_reg),
        .page_number     (in_page_reg),
        .end_of_sequence (in_eos_reg),
        .nxt_state       (state_next),
        .result          (out_next)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= FRAMES_IN_USE_RST;
        end else if (cfg_wr_en) begin
            frames_in_use_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_page_reg <= s_page_number;
            in_eos_reg  <= s_end_of_sequence;
        end
    end

    // Frame state: control part cleared at reset, pages need no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            state_reg.page <= state_next.page;
        end
        if (!aresetn) begin
            state_reg.valid  <= '0;
            state_reg.rank   <= '0;
            state_reg.faults <= '0;
        end else if (advance) begin
            state_reg.valid  <= state_next.valid;
            state_reg.rank   <= state_next.rank;
            state_reg.faults <= state_next.faults;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_hit           = out_reg.hit;
    assign m_frame_slot    = out_reg.frame_slot;
    assign m_evicted_valid = out_reg.evicted_valid;
    assign m_evicted_page  = out_reg.evicted_page;
    assign m_fault_count   = out_reg.fault_count;

endmodule

`default_nettype wire
